[rtl/spdcrc_pkg.sv]
// shared types and constants for the serial packet deframer with crc8 checks
package spdcrc_pkg;

    // input beat codes
    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_RD_ERR  = 2'd2
    } opcode_t;

    // frame sections
    typedef enum logic [2:0] {
        SEC_SYNC     = 3'd0,
        SEC_HEADER   = 3'd1,
        SEC_HDR_CRC  = 3'd2,
        SEC_DATA     = 3'd3,
        SEC_OPTIONAL = 3'd4,
        SEC_DATA_CRC = 3'd5
    } section_t;

    // frame status codes
    typedef enum logic [2:0] {
        ST_CONT      = 3'd0,
        ST_GOOD      = 3'd1,
        ST_HDR_CRC   = 3'd2,
        ST_ZERO_LEN  = 3'd3,
        ST_DATA_CRC  = 3'd4,
        ST_TIMEOUT   = 3'd5,
        ST_RD_ERR    = 3'd6
    } status_t;

    // crc8, msb first, initial value zero, no final xor
    localparam logic [7:0] CRC_POLY = 8'h07;

    // framing constants
    localparam logic [7:0]  SYNC_BYTE      = 8'h55;
    localparam logic [16:0] HDR_CRC_IDX    = 17'd5;
    localparam logic [16:0] DATA_START     = 17'd6;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] section;
        logic [7:0] packet_type;
        logic [2:0] frame_status;
        logic       frame_last;
    } out_beat_t;

endpackage

[rtl/spdcrc_crc8_step.sv]
// one-byte crc8 update, bitwise over the eight shifts
module spdcrc_crc8_step
    import spdcrc_pkg::*;
(
    input  logic [7:0] crc_in,
    input  logic [7:0] data_in,
    output logic [7:0] crc_out
);

    // shift the xored byte through the polynomial
    always_comb begin
        logic [7:0] c;
        c = crc_in ^ data_in;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

[rtl/serial_packet_deframer_crc8.sv]
// serial packet deframer: sync search, header and payload crc8 checks, per-byte results
//
//   channel | ports                     | carries
//   --------+---------------------------+--------------------------------------
//   input   | s_valid, s_ready, s_data  | received byte or link event (in_beat_t)
//   result  | m_valid, m_ready, m_data  | frame byte, section, type, status
//
// every input beat is handled in the cycle it is accepted; its result (if any) sits in
// the output register from the next cycle on: one beat per cycle unless m_ready stalls.
// s_ready is high whenever the output register is empty or being drained.
// aresetn (synchronous, active low) leaves the block out of frame, no result held.
// a stalled result only holds back the next input beat, nothing else.
module serial_packet_deframer_crc8
    import spdcrc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic        in_frame_reg,  in_frame_next;
    logic [16:0] count_reg,     count_next;
    logic [15:0] data_len_reg,  data_len_next;
    logic [7:0]  opt_len_reg,   opt_len_next;
    logic [7:0]  type_reg,      type_next;
    logic [7:0]  crc_reg,       crc_next;
    logic [16:0] exp_size_reg,  exp_size_next;
    logic        m_valid_reg,   m_valid_next;
    out_beat_t   m_data_reg,    m_data_next;

    logic        accept;
    logic        emit;
    logic [7:0]  crc_upd;
    logic [16:0] total;
    logic [16:0] data_idx;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    spdcrc_crc8_step u_crc (
        .crc_in  (crc_reg),
        .data_in (s_data.rx_byte),
        .crc_out (crc_upd)
    );

    assign total    = {1'b0, data_len_reg} + {9'd0, opt_len_reg};
    assign data_idx = count_reg - DATA_START;

    // framing state and result selection
    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        data_len_next = data_len_reg;
        opt_len_next  = opt_len_reg;
        type_next     = type_reg;
        crc_next      = crc_reg;
        exp_size_next = exp_size_reg;
        emit          = 1'b0;
        m_data_next   = m_data_reg;

        if (accept) begin
            case (s_data.opcode)
                OP_TIMEOUT, OP_RD_ERR: begin
                    if (in_frame_reg) begin
                        in_frame_next            = 1'b0;
                        count_next               = '0;
                        emit                     = 1'b1;
                        m_data_next.out_byte     = '0;
                        m_data_next.section      = SEC_SYNC;
                        m_data_next.frame_status = (s_data.opcode == OP_TIMEOUT)
                                                   ? ST_TIMEOUT : ST_RD_ERR;
                        m_data_next.frame_last   = 1'b1;
                    end
                end
                OP_BYTE: begin
                    m_data_next.out_byte     = s_data.rx_byte;
                    m_data_next.frame_status = ST_CONT;
                    m_data_next.frame_last   = 1'b0;
                    if (!in_frame_reg) begin
                        // hunt for sync
                        if (s_data.rx_byte == SYNC_BYTE) begin
                            in_frame_next       = 1'b1;
                            count_next          = 17'd1;
                            type_next           = '0;
                            crc_next            = '0;
                            emit                = 1'b1;
                            m_data_next.section = SEC_SYNC;
                        end
                    end else if (count_reg < HDR_CRC_IDX) begin
                        // header bytes
                        case (count_reg[2:0])
                            3'd1:    data_len_next[15:8] = s_data.rx_byte;
                            3'd2:    data_len_next[7:0]  = s_data.rx_byte;
                            3'd3:    opt_len_next        = s_data.rx_byte;
                            default: type_next           = s_data.rx_byte;
                        endcase
                        crc_next            = crc_upd;
                        count_next          = count_reg + 17'd1;
                        emit                = 1'b1;
                        m_data_next.section = SEC_HEADER;
                    end else if (count_reg == HDR_CRC_IDX) begin
                        // header crc check
                        emit                = 1'b1;
                        m_data_next.section = SEC_HDR_CRC;
                        if (crc_reg != s_data.rx_byte) begin
                            in_frame_next            = 1'b0;
                            count_next               = '0;
                            m_data_next.frame_status = ST_HDR_CRC;
                            m_data_next.frame_last   = 1'b1;
                        end else if (total == '0) begin
                            in_frame_next            = 1'b0;
                            count_next               = '0;
                            m_data_next.frame_status = ST_ZERO_LEN;
                            m_data_next.frame_last   = 1'b1;
                        end else begin
                            exp_size_next = total + FRAME_OVERHEAD;
                            crc_next      = '0;
                            count_next    = DATA_START;
                        end
                    end else if (count_reg + 17'd1 < exp_size_reg) begin
                        // data and optional bytes
                        crc_next            = crc_upd;
                        count_next          = count_reg + 17'd1;
                        emit                = 1'b1;
                        m_data_next.section = (data_idx < {1'b0, data_len_reg})
                                              ? SEC_DATA : SEC_OPTIONAL;
                    end else begin
                        // closing crc byte
                        in_frame_next            = 1'b0;
                        count_next               = '0;
                        emit                     = 1'b1;
                        m_data_next.section      = SEC_DATA_CRC;
                        m_data_next.frame_status = (crc_reg == s_data.rx_byte)
                                                   ? ST_GOOD : ST_DATA_CRC;
                        m_data_next.frame_last   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        m_data_next.packet_type = type_next;

        if (accept) begin
            m_valid_next = emit;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            data_len_reg <= '0;
            opt_len_reg  <= '0;
            type_reg     <= '0;
            crc_reg      <= '0;
            exp_size_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            data_len_reg <= data_len_next;
            opt_len_reg  <= opt_len_next;
            type_reg     <= type_next;
            crc_reg      <= crc_next;
            exp_size_reg <= exp_size_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

[verif/tb_top.sv]
// testbench for the serial packet deframer: frames, link events and crc errors checked per beat
module tb_top;
    import spdcrc_pkg::*;

    // code the block ignores, outside the package enum
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT_TIME = 4_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BEATS = 800;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    int idle_pct = 37;
    int err_count = 0;
    int beats_sent = 0;

    // predicted deframer state
    logic        pf_in_frame = 1'b0;
    logic [16:0] pf_index = '0;
    logic [15:0] pf_data_len = '0;
    logic [7:0]  pf_opt_len = '0;
    logic [7:0]  pf_type = '0;
    logic [7:0]  pf_crc = '0;
    logic [16:0] pf_frame_size = '0;

    // predicted result beats, oldest first
    out_beat_t frame_beats_q[$];

    serial_packet_deframer_crc8 i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock, period 8
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // crc8 over one byte, msb first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic out_beat_t make_beat(input logic [7:0] b, input logic [2:0] sec,
                                            input logic [2:0] st, input logic last);
        out_beat_t r;
        r.out_byte     = b;
        r.section      = sec;
        r.packet_type  = pf_type;
        r.frame_status = st;
        r.frame_last   = last;
        return r;
    endfunction

    // append one predicted beat at the tail
    function automatic void queue_beat(input out_beat_t r);
        frame_beats_q = {frame_beats_q, r};
    endfunction

    // advance the predicted deframer by one accepted beat
    task automatic deframe_predict(input in_beat_t beat);
        logic [7:0]  b;
        logic [16:0] total;
        b = beat.rx_byte;
        if (beat.opcode == OP_TIMEOUT || beat.opcode == OP_RD_ERR) begin
            // link events only matter inside a frame
            if (pf_in_frame) begin
                pf_in_frame = 1'b0;
                pf_index    = '0;
                queue_beat(make_beat(8'h00, SEC_SYNC,
                    (beat.opcode == OP_TIMEOUT) ? ST_TIMEOUT : ST_RD_ERR, 1'b1));
            end
        end else if (beat.opcode == OP_BYTE) begin
            if (!pf_in_frame) begin
                // sync search
                if (b == SYNC_BYTE) begin
                    pf_in_frame = 1'b1;
                    pf_index    = 17'd1;
                    pf_type     = '0;
                    pf_crc      = '0;
                    queue_beat(make_beat(b, SEC_SYNC, ST_CONT, 1'b0));
                end
            end else if (pf_index < HDR_CRC_IDX) begin
                // header bytes
                case (pf_index)
                    17'd1:   pf_data_len[15:8] = b;
                    17'd2:   pf_data_len[7:0] = b;
                    17'd3:   pf_opt_len = b;
                    default: pf_type = b;
                endcase
                pf_crc   = crc8_next(pf_crc, b);
                pf_index = pf_index + 17'd1;
                queue_beat(make_beat(b, SEC_HEADER, ST_CONT, 1'b0));
            end else if (pf_index == HDR_CRC_IDX) begin
                // header crc and length checks
                total = {1'b0, pf_data_len} + {9'd0, pf_opt_len};
                if (pf_crc != b) begin
                    pf_in_frame = 1'b0;
                    pf_index    = '0;
                    queue_beat(make_beat(b, SEC_HDR_CRC, ST_HDR_CRC, 1'b1));
                end else if (total == '0) begin
                    pf_in_frame = 1'b0;
                    pf_index    = '0;
                    queue_beat(make_beat(b, SEC_HDR_CRC, ST_ZERO_LEN, 1'b1));
                end else begin
                    pf_frame_size = total + FRAME_OVERHEAD;
                    pf_crc        = '0;
                    pf_index      = DATA_START;
                    queue_beat(make_beat(b, SEC_HDR_CRC, ST_CONT, 1'b0));
                end
            end else if (pf_index + 17'd1 < pf_frame_size) begin
                // data then optional bytes
                pf_crc = crc8_next(pf_crc, b);
                queue_beat(make_beat(b,
                    (pf_index - DATA_START < {1'b0, pf_data_len}) ? SEC_DATA : SEC_OPTIONAL,
                    ST_CONT, 1'b0));
                pf_index = pf_index + 17'd1;
            end else begin
                // closing crc
                pf_in_frame = 1'b0;
                pf_index    = '0;
                queue_beat(make_beat(b, SEC_DATA_CRC,
                    (pf_crc == b) ? ST_GOOD : ST_DATA_CRC, 1'b1));
            end
        end
    endtask

    // drive one beat from a falling edge, return at the falling edge after acceptance
    task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
        in_beat_t beat;
        beat.opcode  = op;
        beat.rx_byte = b;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        deframe_predict(beat);
        beats_sent++;
        @(negedge aclk);
    endtask

    // hold off the sender until every predicted beat has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (frame_beats_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // one frame byte, or a link event in its place at the cut position, now and then after an unused-code beat
    task automatic put_frame_byte(input logic [7:0] b, input int cut_at,
                                  inout int pos, inout bit cut);
        if (cut) return;
        if ($urandom_range(49) == 0) send_beat(OP_UNUSED, 8'($urandom_range(255)));
        if (pos == cut_at) begin
            send_beat($urandom_range(1) ? OP_TIMEOUT : OP_RD_ERR, 8'($urandom_range(255)));
            cut = 1'b1;
        end else begin
            send_beat(OP_BYTE, b);
        end
        pos++;
    endtask

    // whole frame with random payload; cut_at < 0 means no link event
    task automatic send_frame(input logic [15:0] dlen, input logic [7:0] olen,
                              input logic [7:0] ptype, input bit bad_hdr,
                              input bit bad_data, input int cut_at);
        logic [7:0]  crc;
        logic [7:0]  b;
        logic [16:0] total;
        int          pos;
        bit          cut;
        pos = 0;
        cut = 1'b0;
        crc = '0;
        put_frame_byte(SYNC_BYTE, cut_at, pos, cut);
        crc = crc8_next(crc, dlen[15:8]);
        put_frame_byte(dlen[15:8], cut_at, pos, cut);
        crc = crc8_next(crc, dlen[7:0]);
        put_frame_byte(dlen[7:0], cut_at, pos, cut);
        crc = crc8_next(crc, olen);
        put_frame_byte(olen, cut_at, pos, cut);
        crc = crc8_next(crc, ptype);
        put_frame_byte(ptype, cut_at, pos, cut);
        if (bad_hdr) crc = crc ^ 8'($urandom_range(1, 255));
        put_frame_byte(crc, cut_at, pos, cut);
        total = {1'b0, dlen} + {9'd0, olen};
        if (bad_hdr || total == '0) return;
        crc = '0;
        for (int i = 0; i < int'(total) && !cut; i++) begin
            b   = 8'($urandom_range(255));
            crc = crc8_next(crc, b);
            put_frame_byte(b, cut_at, pos, cut);
        end
        if (bad_data) crc = crc ^ 8'($urandom_range(1, 255));
        put_frame_byte(crc, cut_at, pos, cut);
    endtask

    // non-sync noise byte
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == SYNC_BYTE) ? 8'h54 : b;
    endfunction

    // events and bytes outside any frame produce nothing
    task automatic test_idle_events();
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_TIMEOUT, 8'h55);
        send_beat(OP_RD_ERR, 8'hAA);
        send_beat(OP_UNUSED, 8'h55);
        send_beat(OP_BYTE, 8'hAA);
    endtask

    // each crc, length and good outcome and every section, plus cut frames with a random link event
    task automatic test_directed_frames();
        send_frame(16'd1, 8'd0, 8'h01, 1'b0, 1'b0, -1);
        send_frame(16'd0, 8'd1, 8'hFF, 1'b0, 1'b0, -1);
        send_frame(16'd0, 8'd0, 8'h0A, 1'b0, 1'b0, -1);
        send_frame(16'd2, 8'd1, 8'h5A, 1'b1, 1'b0, -1);
        send_frame(16'd1, 8'd1, 8'h00, 1'b0, 1'b1, -1);
        send_frame(16'd3, 8'd0, 8'h22, 1'b0, 1'b0, 3);
        send_frame(16'd3, 8'd2, 8'h33, 1'b0, 1'b0, 5);
        send_frame(16'd3, 8'd2, 8'h44, 1'b0, 1'b0, 8);
        send_frame(16'd3, 8'd2, 8'hA5, 1'b0, 1'b0, -1);
    endtask

    // length fields at their widest, long frames kept few
    task automatic test_large_lengths();
        send_frame(16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b0, -1);
        send_frame(16'hFFFF, 8'hFF, 8'h80, 1'b0, 1'b0, 12);
        send_frame(16'h0000, 8'hFF, 8'h7E, 1'b0, 1'b0, -1);
        send_frame(16'd300, 8'd255, 8'h3C, 1'b0, 1'b0, -1);
        wait_drained();
    endtask

    // back to back beats, both sides always ready
    task automatic test_no_idle_stretch();
        idle_pct = 0;
        repeat (20) begin
            send_frame(16'($urandom_range(0, 10)), 8'($urandom_range(0, 4)),
                       8'($urandom_range(255)),
                       $urandom_range(9) == 0, $urandom_range(9) == 0, -1);
        end
        idle_pct = 37;
    endtask

    // mostly well-formed frames, some broken, plus noise and events
    task automatic test_random_traffic();
        int target;
        int pick;
        int dlen;
        int olen;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                dlen = $urandom_range(0, 12);
                olen = $urandom_range(0, 6);
                send_frame(16'(dlen), 8'(olen), 8'($urandom_range(255)),
                           $urandom_range(99) < 8, $urandom_range(99) < 10,
                           ($urandom_range(99) < 8) ? int'($urandom_range(0, dlen + olen + 6))
                                                    : -1);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) send_beat(OP_BYTE, noise_byte());
            end else if (pick < 95) begin
                case ($urandom_range(2))
                    0:       send_beat(OP_TIMEOUT, 8'($urandom_range(255)));
                    1:       send_beat(OP_RD_ERR, 8'($urandom_range(255)));
                    default: send_beat(OP_UNUSED, 8'($urandom_range(255)));
                endcase
            end else begin
                wait_drained();
            end
        end
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_beats_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_data);
                err_count++;
            end else begin
                want = frame_beats_q.pop_front();
                check_field("out_byte", want.out_byte, m_data.out_byte);
                check_field("section", 8'(want.section), 8'(m_data.section));
                check_field("packet_type", want.packet_type, m_data.packet_type);
                check_field("frame_status", 8'(want.frame_status), 8'(m_data.frame_status));
                check_field("frame_last", 8'(want.frame_last), 8'(m_data.frame_last));
            end
        end
    end

    // reset, tests in turn, final verdict
    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_events();
        test_directed_frames();
        test_large_lengths();
        test_no_idle_stretch();
        test_random_traffic();
        wait_drained();
        if (err_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #LIMIT_TIME;
        $display("tb_top failed");
        $finish;
    end

endmodule

[files.f]
rtl/spdcrc_pkg.sv
rtl/spdcrc_crc8_step.sv
rtl/serial_packet_deframer_crc8.sv
verif/tb_top.sv
